// ===== src/ctf_pkg.sv =====
// types, constants and character classes shared by the csv field tokenizer
`timescale 1ns / 1ps
`default_nettype none

package ctf_pkg;

    localparam int SPACE_DEPTH = 15;
    localparam int CNT_W       = $clog2(SPACE_DEPTH + 1);
    localparam int IDX_W       = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

    localparam logic       FUNC_UNIT = 1'b0;
    localparam logic       FUNC_EOL  = 1'b1;
    localparam logic       KIND_CHAR = 1'b0;
    localparam logic       KIND_EOF  = 1'b1;
    localparam logic [15:0] CH_QUOTE = 16'h0022;
    localparam logic [15:0] CH_COMMA = 16'h002C;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [IDX_W-1:0] idx_t;

    // work item handed from the front to the back
    typedef struct packed {
        logic        is_eof;
        logic [15:0] ch;
        cnt_t        nsp;
        logic        line;
        logic        lost;
    } cmd_t;

    // write port of the held whitespace buffer
    typedef struct packed {
        logic        en;
        idx_t        addr;
        logic [15:0] data;
    } hold_wr_t;

    function automatic logic is_ws(input logic [15:0] c);
        logic r;
        r = (c == 16'h0020) || ((c >= 16'h0009) && (c <= 16'h000D)) ||
            (c == 16'h0085) || (c == 16'h00A0) || (c == 16'h1680) ||
            ((c >= 16'h2000) && (c <= 16'h200A)) ||
            (c == 16'h2028) || (c == 16'h2029) || (c == 16'h202F) ||
            (c == 16'h205F) || (c == 16'h3000);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/ctf_if.sv =====
// stream interfaces for text code units and field tokens
`timescale 1ns / 1ps
`default_nettype none

interface ctf_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] code_unit;

    modport source (output valid, output func, output code_unit, input ready);
    modport sink   (input valid, input func, input code_unit, output ready);
endinterface

interface ctf_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] char_out;
    logic        line_done;
    logic        space_lost;
    logic        last;

    modport source (output valid, output kind, output char_out, output line_done,
                    output space_lost, output last, input ready);
    modport sink   (input valid, input kind, input char_out, input line_done,
                    input space_lost, input last, output ready);
endinterface

`default_nettype wire

// ===== src/ctf_front.sv =====
// front end: quote tracking, field trimming state and command generation
`timescale 1ns / 1ps
`default_nettype none

module ctf_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    ctf_in_if.sink                 text,
    input  wire logic              q_full,
    input  wire logic              flush_done,
    output      logic              push,
    output      ctf_pkg::cmd_t     push_cmd,
    output      ctf_pkg::hold_wr_t hold_wr
);

    logic          in_quotes_reg, in_quotes_next;
    logic          quote_pending_reg, quote_pending_next;
    logic          field_started_reg, field_started_next;
    ctf_pkg::cnt_t held_count_reg, held_count_next;
    logic          overflow_seen_reg, overflow_seen_next;
    logic          flush_pending_reg, flush_pending_next;

    logic          fire;
    logic          proc;
    logic          q_eff;
    logic [15:0]   c;

    assign text.ready = !q_full && !flush_pending_reg;
    assign fire       = text.valid && text.ready;
    assign c          = text.code_unit;

    always_comb
    begin
        in_quotes_next     = in_quotes_reg;
        quote_pending_next = quote_pending_reg;
        field_started_next = field_started_reg;
        held_count_next    = held_count_reg;
        overflow_seen_next = overflow_seen_reg;
        flush_pending_next = flush_pending_reg && !flush_done;
        push               = 1'b0;
        push_cmd           = '0;
        hold_wr            = '0;
        proc               = 1'b0;
        q_eff              = in_quotes_reg;
        if (fire)
        begin
            if (text.func == ctf_pkg::FUNC_EOL)
            begin
                push               = 1'b1;
                push_cmd.is_eof    = 1'b1;
                push_cmd.line      = 1'b1;
                push_cmd.lost      = overflow_seen_reg;
                in_quotes_next     = 1'b0;
                quote_pending_next = 1'b0;
                field_started_next = 1'b0;
                held_count_next    = '0;
                overflow_seen_next = 1'b0;
            end
            else
            begin
                proc = 1'b1;
                if (quote_pending_reg)
                begin
                    quote_pending_next = 1'b0;
                    if (c == ctf_pkg::CH_QUOTE)
                    begin
                        // doubled quote gives a literal quote
                        proc               = 1'b0;
                        push               = 1'b1;
                        push_cmd.ch        = ctf_pkg::CH_QUOTE;
                        push_cmd.nsp       = held_count_reg;
                        held_count_next    = '0;
                        field_started_next = 1'b1;
                        flush_pending_next = (held_count_reg != '0);
                    end
                    else
                    begin
                        in_quotes_next = 1'b0;
                        q_eff          = 1'b0;
                    end
                end
                if (proc)
                begin
                    if (c == ctf_pkg::CH_QUOTE)
                    begin
                        if (q_eff)
                            quote_pending_next = 1'b1;
                        else
                            in_quotes_next = 1'b1;
                    end
                    else if ((c == ctf_pkg::CH_COMMA) && !q_eff)
                    begin
                        push               = 1'b1;
                        push_cmd.is_eof    = 1'b1;
                        push_cmd.lost      = overflow_seen_reg;
                        field_started_next = 1'b0;
                        held_count_next    = '0;
                        overflow_seen_next = 1'b0;
                    end
                    else if (ctf_pkg::is_ws(c))
                    begin
                        if (field_started_reg)
                        begin
                            if (held_count_reg < ctf_pkg::CNT_W'(ctf_pkg::SPACE_DEPTH))
                            begin
                                hold_wr.en      = 1'b1;
                                hold_wr.addr    = held_count_reg[ctf_pkg::IDX_W-1:0];
                                hold_wr.data    = c;
                                held_count_next = held_count_reg + 1'b1;
                            end
                            else
                            begin
                                overflow_seen_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        push               = 1'b1;
                        push_cmd.ch        = c;
                        push_cmd.nsp       = held_count_reg;
                        held_count_next    = '0;
                        field_started_next = 1'b1;
                        flush_pending_next = (held_count_reg != '0);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg     <= 1'b0;
            quote_pending_reg <= 1'b0;
            field_started_reg <= 1'b0;
            held_count_reg    <= '0;
            overflow_seen_reg <= 1'b0;
            flush_pending_reg <= 1'b0;
        end
        else
        begin
            in_quotes_reg     <= in_quotes_next;
            quote_pending_reg <= quote_pending_next;
            field_started_reg <= field_started_next;
            held_count_reg    <= held_count_next;
            overflow_seen_reg <= overflow_seen_next;
            flush_pending_reg <= flush_pending_next;
        end
    end

    a_pending_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
        quote_pending_reg |-> in_quotes_reg)
        else $error("quote pending outside quoted mode");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= ctf_pkg::CNT_W'(ctf_pkg::SPACE_DEPTH))
        else $error("held count beyond buffer depth");

    a_held_needs_field: assert property (@(posedge clk) disable iff (!rst_n)
        (held_count_reg != '0) |-> field_started_reg)
        else $error("whitespace held before field start");

    a_no_write_during_flush: assert property (@(posedge clk) disable iff (!rst_n)
        flush_pending_reg |-> !hold_wr.en)
        else $error("held buffer written while a flush is outstanding");

endmodule

`default_nettype wire

// ===== src/ctf_queue.sv =====
// two-entry command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module ctf_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ctf_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output      logic          full,
    output      logic          head_valid,
    output      ctf_pkg::cmd_t head
);

    ctf_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("transfer into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== src/ctf_back.sv =====
// back end: held whitespace buffer, space flushing and output register
`timescale 1ns / 1ps
`default_nettype none

module ctf_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctf_pkg::hold_wr_t hold_wr,
    input  wire logic              head_valid,
    input  wire ctf_pkg::cmd_t     head,
    output      logic              pop,
    output      logic              flush_done,
    ctf_out_if.source              tokens
);

    logic [15:0]   held_reg [ctf_pkg::SPACE_DEPTH];
    ctf_pkg::cnt_t idx_reg, idx_next;

    logic          out_valid_reg, out_valid_next;
    logic          kind_reg, kind_next;
    logic [15:0]   char_reg, char_next;
    logic          line_reg, line_next;
    logic          lost_reg, lost_next;
    logic          last_reg, last_next;

    logic          load;
    logic          space_phase;

    assign load        = head_valid && (!out_valid_reg || tokens.ready);
    assign space_phase = (idx_reg < head.nsp);

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !tokens.ready;
        kind_next      = kind_reg;
        char_next      = char_reg;
        line_next      = line_reg;
        lost_next      = lost_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        flush_done     = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (space_phase)
            begin
                kind_next  = ctf_pkg::KIND_CHAR;
                char_next  = held_reg[idx_reg[ctf_pkg::IDX_W-1:0]];
                line_next  = 1'b0;
                lost_next  = 1'b0;
                last_next  = 1'b0;
                idx_next   = idx_reg + 1'b1;
                flush_done = (idx_next == head.nsp);
            end
            else
            begin
                kind_next = head.is_eof ? ctf_pkg::KIND_EOF : ctf_pkg::KIND_CHAR;
                char_next = head.is_eof ? 16'h0000 : head.ch;
                line_next = head.line;
                lost_next = head.lost;
                last_next = 1'b1;
                idx_next  = '0;
                pop       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_wr.en)
            held_reg[hold_wr.addr] <= hold_wr.data;
        kind_reg <= kind_next;
        char_reg <= char_next;
        line_reg <= line_next;
        lost_reg <= lost_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign tokens.valid      = out_valid_reg;
    assign tokens.kind       = kind_reg;
    assign tokens.char_out   = char_reg;
    assign tokens.line_done  = line_reg;
    assign tokens.space_lost = lost_reg;
    assign tokens.last       = last_reg;

    a_idx_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> (head_valid && (idx_reg <= head.nsp)))
        else $error("flush index without a matching command");

    a_space_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && space_phase) |=> (out_valid_reg && !last_reg &&
                                   (kind_reg == ctf_pkg::KIND_CHAR)))
        else $error("held space transfer marked last or end of field");

    a_pop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid_reg && last_reg))
        else $error("command finished without a last transfer");

    a_flush_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && space_phase) |-> !hold_wr.en)
        else $error("held buffer overwritten during flush");

endmodule

`default_nettype wire

// ===== src/csv_field_tokenizer.sv =====
// csv field tokenizer top level: front end, command queue and back end
// an item's first result passes the command queue and then the output register
// throughput: one code unit per cycle while the command queue has room; a character after k
// held spaces gives k+1 results, and input holds off until the back end has read the spaces
// the back end output register delivers one result per cycle while the sink is ready
// reset: asynchronous active low, clears quote, field and queue state; buffer is not cleared
`timescale 1ns / 1ps
`default_nettype none

module csv_field_tokenizer (
    input  wire logic clk,
    input  wire logic rst_n,
    ctf_in_if.sink    text,
    ctf_out_if.source tokens
);

    logic              push;
    ctf_pkg::cmd_t     push_cmd;
    ctf_pkg::hold_wr_t hold_wr;
    logic              q_full;
    logic              head_valid;
    ctf_pkg::cmd_t     head;
    logic              pop;
    logic              flush_done;

    ctf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .q_full     (q_full),
        .flush_done (flush_done),
        .push       (push),
        .push_cmd   (push_cmd),
        .hold_wr    (hold_wr)
    );

    ctf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    ctf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold_wr    (hold_wr),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .flush_done (flush_done),
        .tokens     (tokens)
    );

endmodule

`default_nettype wire
